>>> rtl/core/febl_pkg.sv
// shared types, constants and helpers for the erase block log cache
// depends on nothing; used by fifo_erase_block_log_cache_top
`default_nettype none

package febl_pkg;

    localparam int NUM_BLOCKS      = 16;
    localparam int SLOTS_PER_BLOCK = 32;
    localparam int KEY_BITS        = 32;

    localparam int NUM_SLOTS = NUM_BLOCKS * SLOTS_PER_BLOCK;
    localparam int BLK_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int SLOT_W    = (SLOTS_PER_BLOCK > 1) ? $clog2(SLOTS_PER_BLOCK) : 1;
    localparam int ADDR_W    = $clog2(NUM_SLOTS);
    localparam int USED_W    = $clog2(SLOTS_PER_BLOCK + 1);

    localparam int CMD_W   = 2;
    localparam int ID_W    = 32;
    localparam int SIZE_W  = 20;
    localparam int FILL_W  = 24;
    localparam int TOTAL_W = 28;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERSIZE  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DUPLICATE = 2'd2;

    localparam logic KIND_DONE  = 1'b0;
    localparam logic KIND_EVICT = 1'b1;

    localparam logic CFG_BLOCK_CAP = 1'b0;
    localparam logic CFG_LAST_CAP  = 1'b1;

    localparam logic [FILL_W-1:0] CAP_RESET = 24'd262144;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ID_W-1:0]   item_id;
        logic [SIZE_W-1:0] item_size;
    } t_in;

    typedef struct packed {
        logic               kind;
        logic [ID_W-1:0]    out_id;
        logic [SIZE_W-1:0]  out_size;
        logic               hit;
        logic [STAT_W-1:0]  status;
        logic               last;
        logic [TOTAL_W-1:0] used_bytes;
    } t_out;

    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic [SIZE_W-1:0]   bytes;
    } t_slot;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic [USED_W-1:0] used;
    } t_blk;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DROP_RD,
        S_DROP_WR,
        S_SUM,
        S_FL_RD,
        S_FL_CHK,
        S_FL_END,
        S_INS_RD,
        S_INS_WR,
        S_DONE
    } t_state;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [BLK_W-1:0] b,
                                                    input logic [SLOT_W-1:0] s);
        slot_addr = ADDR_W'(ADDR_W'(b) * ADDR_W'(SLOTS_PER_BLOCK)) + ADDR_W'(s);
    endfunction

    function automatic logic [BLK_W-1:0] next_blk(input logic [BLK_W-1:0] b);
        next_blk = (b == BLK_W'(NUM_BLOCKS - 1)) ? '0 : b + 1'b1;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/fifo_erase_block_log_cache_top.sv
// erase block log cache: fsm around a slot memory and a block memory
// depends on febl_pkg
// operation: every command scans all NUM_SLOTS slots, one read a cycle; an update
// that removes its old copy adds a read and a write of its block, and a
// block advance adds a summing pass over the next block and a flush that reads
// and checks each of its slots in turn, plus any stall on the result side
// throughput: one command at a time, set by the single read port of the slot memory
// reset: synchronous active low; afterwards a clearing pass over all NUM_SLOTS slots
// marks every slot empty, no command is taken during it (config writes are)
`default_nettype none

module fifo_erase_block_log_cache_top (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire febl_pkg::t_in           i_in_data,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output febl_pkg::t_out               o_out_data,
    input  wire logic                    i_cfg_we,
    input  wire logic                    i_cfg_idx,
    input  wire logic [febl_pkg::FILL_W-1:0] i_cfg_data
);

    // storage
    febl_pkg::t_slot slot_mem [febl_pkg::NUM_SLOTS];
    febl_pkg::t_blk  blk_mem  [febl_pkg::NUM_BLOCKS];
    logic [febl_pkg::NUM_BLOCKS-1:0] r_blk_vld;

    febl_pkg::t_slot r_slot_q;
    febl_pkg::t_blk  r_blk_q;
    logic            r_blk_qv;
    febl_pkg::t_blk  blk_rd;

    // memory control
    logic                          slot_re, slot_we;
    logic [febl_pkg::ADDR_W-1:0]   slot_ra, slot_wa;
    febl_pkg::t_slot               slot_wd;
    logic                          blk_re, blk_we;
    logic [febl_pkg::BLK_W-1:0]    blk_ra, blk_wa;
    febl_pkg::t_blk                blk_wd;

    // control and working registers
    febl_pkg::t_state r_state, n_state;
    logic [febl_pkg::CMD_W-1:0]   r_cmd, n_cmd;
    logic [febl_pkg::ID_W-1:0]    r_id, n_id;
    logic [febl_pkg::SIZE_W-1:0]  r_size, n_size;
    logic [febl_pkg::BLK_W-1:0]   r_open, n_open;
    logic [febl_pkg::BLK_W-1:0]   r_nb, n_nb;
    logic [febl_pkg::TOTAL_W-1:0] r_total, n_total;
    logic [febl_pkg::TOTAL_W-1:0] r_sum, n_sum;
    logic [febl_pkg::TOTAL_W-1:0] r_final, n_final;
    logic [febl_pkg::FILL_W-1:0]  r_cap, r_last_cap;
    logic [febl_pkg::BLK_W-1:0]   r_sb, n_sb;
    logic [febl_pkg::SLOT_W-1:0]  r_ss, n_ss;
    logic                         r_issue_done, n_issue_done;
    logic                         r_rd_vld;
    logic [febl_pkg::BLK_W-1:0]   r_rd_b;
    logic [febl_pkg::SLOT_W-1:0]  r_rd_s;
    logic                         r_found, n_found;
    logic [febl_pkg::BLK_W-1:0]   r_old_b, n_old_b;
    logic [febl_pkg::SLOT_W-1:0]  r_old_s, n_old_s;
    logic [febl_pkg::SIZE_W-1:0]  r_old_sz, n_old_sz;
    logic                         r_free_found, n_free_found;
    logic [febl_pkg::SLOT_W-1:0]  r_free_s, n_free_s;
    logic                         r_fits, n_fits;
    logic [febl_pkg::SLOT_W-1:0]  r_ins_s, n_ins_s;
    logic                         r_ins_ok, n_ins_ok;
    logic                         r_hit, n_hit;
    logic [febl_pkg::STAT_W-1:0]  r_status, n_status;
    logic                         r_out_valid, n_out_valid;
    febl_pkg::t_out               r_out, n_out;

    // decision terms, worked out while the scan drains
    logic                         old_in_ob;
    logic [febl_pkg::FILL_W-1:0]  dec_fill;
    logic [febl_pkg::USED_W-1:0]  dec_used;
    logic [febl_pkg::FILL_W:0]    dec_sum;
    logic [febl_pkg::FILL_W-1:0]  cap_ob, cap_nb;
    logic                         dec_fits;
    logic                         out_free;
    logic                         last_slot;
    logic                         key_match;

    assign blk_rd    = r_blk_qv ? r_blk_q : '0;
    assign out_free  = !r_out_valid || i_out_ready;
    assign last_slot = (r_ss == febl_pkg::SLOT_W'(febl_pkg::SLOTS_PER_BLOCK - 1));
    assign key_match = (r_slot_q.key == febl_pkg::KEY_BITS'(r_id));

    assign cap_ob = (r_open == febl_pkg::BLK_W'(febl_pkg::NUM_BLOCKS - 1)) ?
                    r_last_cap : r_cap;
    assign cap_nb = (febl_pkg::next_blk(r_open) == febl_pkg::BLK_W'(febl_pkg::NUM_BLOCKS - 1)) ?
                    r_last_cap : r_cap;

    assign old_in_ob = r_found && (r_cmd == febl_pkg::CMD_UPDATE) && (r_old_b == r_open);

    always_comb begin
        dec_fill = blk_rd.fill;
        dec_used = blk_rd.used;
        if (old_in_ob) begin
            dec_fill = (blk_rd.fill >= febl_pkg::FILL_W'(r_old_sz)) ?
                       blk_rd.fill - febl_pkg::FILL_W'(r_old_sz) : '0;
            if (blk_rd.used != '0) begin
                dec_used = blk_rd.used - 1'b1;
            end
        end
        dec_sum  = {1'b0, dec_fill} + (febl_pkg::FILL_W + 1)'(r_size);
        dec_fits = (dec_sum <= {1'b0, cap_ob}) &&
                   (dec_used < febl_pkg::USED_W'(febl_pkg::SLOTS_PER_BLOCK));
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= febl_pkg::CAP_RESET;
            r_last_cap <= febl_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == febl_pkg::CFG_BLOCK_CAP) begin
                r_cap <= i_cfg_data;
            end else begin
                r_last_cap <= i_cfg_data;
            end
        end
    end

    // memories, read data registered
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        if (slot_re) begin
            r_slot_q <= slot_mem[slot_ra];
        end
        if (blk_we) begin
            blk_mem[blk_wa] <= blk_wd;
        end
        if (blk_re) begin
            r_blk_q <= blk_mem[blk_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_vld <= '0;
            r_blk_qv  <= 1'b0;
        end else begin
            if (blk_we) begin
                r_blk_vld[blk_wa] <= 1'b1;
            end
            if (blk_re) begin
                r_blk_qv <= r_blk_vld[blk_ra];
            end
        end
    end

    // next state, memory control and result beats
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_id         = r_id;
        n_size       = r_size;
        n_open       = r_open;
        n_nb         = r_nb;
        n_total      = r_total;
        n_sum        = r_sum;
        n_final      = r_final;
        n_sb         = r_sb;
        n_ss         = r_ss;
        n_issue_done = r_issue_done;
        n_found      = r_found;
        n_old_b      = r_old_b;
        n_old_s      = r_old_s;
        n_old_sz     = r_old_sz;
        n_free_found = r_free_found;
        n_free_s     = r_free_s;
        n_fits       = r_fits;
        n_ins_s      = r_ins_s;
        n_ins_ok     = r_ins_ok;
        n_hit        = r_hit;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;

        slot_re = 1'b0;
        slot_ra = febl_pkg::slot_addr(r_sb, r_ss);
        slot_we = 1'b0;
        slot_wa = febl_pkg::slot_addr(r_sb, r_ss);
        slot_wd = '0;
        blk_re  = 1'b0;
        blk_ra  = r_open;
        blk_we  = 1'b0;
        blk_wa  = r_open;
        blk_wd  = '0;

        o_in_ready = 1'b0;

        case (r_state)
            febl_pkg::S_CLEAR: begin
                // mark every slot empty
                slot_we = 1'b1;
                n_ss    = r_ss + 1'b1;
                if (last_slot) begin
                    n_ss = '0;
                    n_sb = febl_pkg::next_blk(r_sb);
                    if (r_sb == febl_pkg::BLK_W'(febl_pkg::NUM_BLOCKS - 1)) begin
                        n_state = febl_pkg::S_IDLE;
                    end
                end
            end

            febl_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd        = i_in_data.command;
                    n_id         = i_in_data.item_id;
                    n_size       = i_in_data.item_size;
                    n_sb         = '0;
                    n_ss         = '0;
                    n_issue_done = 1'b0;
                    n_found      = 1'b0;
                    n_free_found = 1'b0;
                    n_hit        = 1'b0;
                    n_status     = febl_pkg::STAT_OK;
                    blk_re       = 1'b1;
                    blk_ra       = r_open;
                    n_state      = febl_pkg::S_SCAN;
                end
            end

            febl_pkg::S_SCAN: begin
                // issue one read a cycle over the whole slot memory
                if (!r_issue_done) begin
                    slot_re = 1'b1;
                    n_ss    = r_ss + 1'b1;
                    if (last_slot) begin
                        n_ss = '0;
                        n_sb = febl_pkg::next_blk(r_sb);
                        if (r_sb == febl_pkg::BLK_W'(febl_pkg::NUM_BLOCKS - 1)) begin
                            n_issue_done = 1'b1;
                        end
                    end
                end
                if (r_rd_vld) begin
                    if (r_slot_q.valid && key_match) begin
                        n_found  = 1'b1;
                        n_old_b  = r_rd_b;
                        n_old_s  = r_rd_s;
                        n_old_sz = r_slot_q.bytes;
                    end
                    if (!r_slot_q.valid && (r_rd_b == r_open) && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_s     = r_rd_s;
                    end
                end
                if (r_issue_done && !r_rd_vld) begin
                    n_nb   = febl_pkg::next_blk(r_open);
                    n_fits = dec_fits;
                    // lowest free slot of the open block, the removed copy included
                    n_ins_ok = r_free_found || old_in_ob;
                    n_ins_s  = r_free_s;
                    if (old_in_ob && (!r_free_found || (r_old_s < r_free_s))) begin
                        n_ins_s = r_old_s;
                    end
                    if (r_cmd != febl_pkg::CMD_INSERT && r_cmd != febl_pkg::CMD_UPDATE) begin
                        n_hit   = r_found;
                        n_state = febl_pkg::S_DONE;
                    end else if (!dec_fits &&
                                 (febl_pkg::FILL_W'(r_size) > cap_nb)) begin
                        n_status = febl_pkg::STAT_OVERSIZE;
                        n_state  = febl_pkg::S_DONE;
                    end else if ((r_cmd == febl_pkg::CMD_INSERT) && r_found) begin
                        n_status = febl_pkg::STAT_DUPLICATE;
                        n_state  = febl_pkg::S_DONE;
                    end else if (r_found) begin
                        n_state = febl_pkg::S_DROP_RD;
                    end else if (dec_fits) begin
                        n_state = febl_pkg::S_INS_RD;
                    end else begin
                        n_ss         = '0;
                        n_issue_done = 1'b0;
                        n_sum        = '0;
                        n_state      = febl_pkg::S_SUM;
                    end
                end
            end

            febl_pkg::S_DROP_RD: begin
                blk_re  = 1'b1;
                blk_ra  = r_old_b;
                n_state = febl_pkg::S_DROP_WR;
            end

            febl_pkg::S_DROP_WR: begin
                // remove the old copy of an update
                slot_we     = 1'b1;
                slot_wa     = febl_pkg::slot_addr(r_old_b, r_old_s);
                slot_wd     = '0;
                blk_we      = 1'b1;
                blk_wa      = r_old_b;
                blk_wd.fill = blk_rd.fill - febl_pkg::FILL_W'(r_old_sz);
                blk_wd.used = (blk_rd.used != '0) ? blk_rd.used - 1'b1 : '0;
                n_total     = r_total - febl_pkg::TOTAL_W'(r_old_sz);
                if (r_fits) begin
                    n_state = febl_pkg::S_INS_RD;
                end else begin
                    n_ss         = '0;
                    n_issue_done = 1'b0;
                    n_sum        = '0;
                    n_state      = febl_pkg::S_SUM;
                end
            end

            febl_pkg::S_SUM: begin
                // live bytes of the block to flush, so every beat carries the final total
                slot_ra = febl_pkg::slot_addr(r_nb, r_ss);
                if (!r_issue_done) begin
                    slot_re = 1'b1;
                    n_ss    = r_ss + 1'b1;
                    if (last_slot) begin
                        n_ss         = '0;
                        n_issue_done = 1'b1;
                    end
                end
                if (r_rd_vld && r_slot_q.valid) begin
                    n_sum = r_sum + febl_pkg::TOTAL_W'(r_slot_q.bytes);
                end
                if (r_issue_done && !r_rd_vld) begin
                    n_final = r_total - r_sum + febl_pkg::TOTAL_W'(r_size);
                    n_ss    = '0;
                    n_state = febl_pkg::S_FL_RD;
                end
            end

            febl_pkg::S_FL_RD: begin
                slot_re = 1'b1;
                slot_ra = febl_pkg::slot_addr(r_nb, r_ss);
                n_state = febl_pkg::S_FL_CHK;
            end

            febl_pkg::S_FL_CHK: begin
                if (r_slot_q.valid) begin
                    if (out_free) begin
                        n_out_valid      = 1'b1;
                        n_out.kind       = febl_pkg::KIND_EVICT;
                        n_out.out_id     = febl_pkg::ID_W'(r_slot_q.key);
                        n_out.out_size   = r_slot_q.bytes;
                        n_out.hit        = 1'b0;
                        n_out.status     = febl_pkg::STAT_OK;
                        n_out.last       = 1'b0;
                        n_out.used_bytes = r_final;
                        slot_we          = 1'b1;
                        slot_wa          = febl_pkg::slot_addr(r_nb, r_ss);
                        slot_wd          = '0;
                        n_total          = r_total - febl_pkg::TOTAL_W'(r_slot_q.bytes);
                        n_ss             = r_ss + 1'b1;
                        n_state          = last_slot ? febl_pkg::S_FL_END : febl_pkg::S_FL_RD;
                    end
                end else begin
                    n_ss    = r_ss + 1'b1;
                    n_state = last_slot ? febl_pkg::S_FL_END : febl_pkg::S_FL_RD;
                end
            end

            febl_pkg::S_FL_END: begin
                // flushed block becomes the open one, empty
                blk_we   = 1'b1;
                blk_wa   = r_nb;
                blk_wd   = '0;
                n_open   = r_nb;
                n_ins_s  = '0;
                n_ins_ok = 1'b1;
                n_state  = febl_pkg::S_INS_RD;
            end

            febl_pkg::S_INS_RD: begin
                blk_re  = 1'b1;
                blk_ra  = r_open;
                n_state = febl_pkg::S_INS_WR;
            end

            febl_pkg::S_INS_WR: begin
                if (r_ins_ok) begin
                    slot_we       = 1'b1;
                    slot_wa       = febl_pkg::slot_addr(r_open, r_ins_s);
                    slot_wd.valid = 1'b1;
                    slot_wd.key   = febl_pkg::KEY_BITS'(r_id);
                    slot_wd.bytes = r_size;
                    blk_we        = 1'b1;
                    blk_wa        = r_open;
                    blk_wd.fill   = blk_rd.fill + febl_pkg::FILL_W'(r_size);
                    blk_wd.used   = blk_rd.used + 1'b1;
                    n_total       = r_total + febl_pkg::TOTAL_W'(r_size);
                end
                n_state = febl_pkg::S_DONE;
            end

            febl_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.kind       = febl_pkg::KIND_DONE;
                    n_out.out_id     = r_id;
                    n_out.out_size   = '0;
                    n_out.hit        = r_hit;
                    n_out.status     = r_status;
                    n_out.last       = 1'b1;
                    n_out.used_bytes = r_total;
                    n_state          = febl_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = febl_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= febl_pkg::S_CLEAR;
            r_open       <= '0;
            r_total      <= '0;
            r_sb         <= '0;
            r_ss         <= '0;
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_open       <= n_open;
            r_total      <= n_total;
            r_sb         <= n_sb;
            r_ss         <= n_ss;
            r_issue_done <= n_issue_done;
            r_rd_vld     <= slot_re && (r_state == febl_pkg::S_SCAN ||
                                        r_state == febl_pkg::S_SUM);
            r_out_valid  <= n_out_valid;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_id         <= n_id;
        r_size       <= n_size;
        r_nb         <= n_nb;
        r_sum        <= n_sum;
        r_final      <= n_final;
        r_rd_b       <= r_sb;
        r_rd_s       <= r_ss;
        r_found      <= n_found;
        r_old_b      <= n_old_b;
        r_old_s      <= n_old_s;
        r_old_sz     <= n_old_sz;
        r_free_found <= n_free_found;
        r_free_s     <= n_free_s;
        r_fits       <= n_fits;
        r_ins_s      <= n_ins_s;
        r_ins_ok     <= n_ins_ok;
        r_hit        <= n_hit;
        r_status     <= n_status;
        r_out        <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> bench/fifo_erase_block_log_cache_top_tb.sv
// testbench for the erase block log cache: random and directed commands,
// checked beat by beat against a behavioural model of the log held in a scoreboard
// depends on febl_pkg and fifo_erase_block_log_cache_top
`default_nettype none

module fifo_erase_block_log_cache_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import febl_pkg::*;

    // behavioural copy of the log, plus the queue of expected result beats
    class log_scoreboard;
        bit                valid_q [NUM_SLOTS];
        bit [KEY_BITS-1:0] key_q [NUM_SLOTS];
        bit [SIZE_W-1:0]   bytes_q [NUM_SLOTS];
        bit [FILL_W-1:0]   fill_q [NUM_BLOCKS];
        int                used_q [NUM_BLOCKS];
        int                open_blk;
        bit [TOTAL_W-1:0]  live_total;
        bit [FILL_W-1:0]   cap_main;
        bit [FILL_W-1:0]   cap_last;
        t_out              pending[$];
        int                errors;
        int                evictions;
        int                beats;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++) valid_q[i] = 0;
            for (int b = 0; b < NUM_BLOCKS; b++) begin
                fill_q[b] = '0;
                used_q[b] = 0;
            end
            open_blk = 0;
            live_total = '0;
            cap_main = CAP_RESET;
            cap_last = CAP_RESET;
            errors = 0;
            evictions = 0;
            beats = 0;
        endfunction

        function bit [FILL_W-1:0] cap_for(int b);
            return (b == NUM_BLOCKS - 1) ? cap_last : cap_main;
        endfunction

        function int find_key(bit [KEY_BITS-1:0] k);
            for (int i = 0; i < NUM_SLOTS; i++)
                if (valid_q[i] && key_q[i] == k) return i;
            return -1;
        endfunction

        function void drop(int idx);
            int b;
            b = idx / SLOTS_PER_BLOCK;
            valid_q[idx] = 0;
            fill_q[b] = fill_q[b] - bytes_q[idx];
            if (used_q[b] > 0) used_q[b]--;
            live_total = live_total - TOTAL_W'(bytes_q[idx]);
        endfunction

        function void note_command(t_in c);
            t_out              r;
            t_out              batch[$];
            bit [KEY_BITS-1:0] k;
            bit [1:0]          st;
            bit                h;
            int                old, ob, nb, base, s;
            longint            fill;
            int                used;
            bit                fits;
            k = c.item_id;
            ob = open_blk;
            st = STAT_OK;
            h = 0;
            if (c.command != CMD_INSERT && c.command != CMD_UPDATE) begin
                h = find_key(k) >= 0;
            end else begin
                old = find_key(k);
                fill = fill_q[ob];
                used = used_q[ob];
                nb = (ob + 1) % NUM_BLOCKS;
                if (c.command == CMD_UPDATE && old >= 0 && old / SLOTS_PER_BLOCK == ob) begin
                    fill = (fill >= bytes_q[old]) ? fill - bytes_q[old] : 0;
                    if (used > 0) used--;
                end
                fits = (fill + c.item_size <= cap_for(ob)) && used < SLOTS_PER_BLOCK;
                if (!fits && c.item_size > cap_for(nb)) begin
                    st = STAT_OVERSIZE;
                end else if (c.command == CMD_INSERT && old >= 0) begin
                    st = STAT_DUPLICATE;
                end else begin
                    if (c.command == CMD_UPDATE && old >= 0) drop(old);
                    if (!fits) begin
                        base = nb * SLOTS_PER_BLOCK;
                        for (int i = 0; i < SLOTS_PER_BLOCK; i++) begin
                            if (valid_q[base + i]) begin
                                r = '0;
                                r.kind = KIND_EVICT;
                                r.out_id = key_q[base + i];
                                r.out_size = bytes_q[base + i];
                                batch = {batch, r};
                                drop(base + i);
                            end
                        end
                        fill_q[nb] = '0;
                        used_q[nb] = 0;
                        open_blk = nb;
                        ob = nb;
                    end
                    for (int i = 0; i < SLOTS_PER_BLOCK; i++) begin
                        s = ob * SLOTS_PER_BLOCK + i;
                        if (!valid_q[s]) begin
                            valid_q[s] = 1;
                            key_q[s] = k;
                            bytes_q[s] = c.item_size;
                            fill_q[ob] = fill_q[ob] + FILL_W'(c.item_size);
                            used_q[ob]++;
                            live_total = live_total + TOTAL_W'(c.item_size);
                            break;
                        end
                    end
                end
            end
            r = '0;
            r.kind = KIND_DONE;
            r.out_id = c.item_id;
            r.hit = h;
            r.status = st;
            r.last = 1'b1;
            batch = {batch, r};
            foreach (batch[i]) begin
                batch[i].used_bytes = live_total;
                pending = {pending, batch[i]};
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            beats++;
            if (got.kind == KIND_EVICT) evictions++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                errors++;
            end
            if (got.out_id !== want.out_id) begin
                $display("%0t: id expected %h actual %h", $time, want.out_id, got.out_id);
                errors++;
            end
            if (got.out_size !== want.out_size) begin
                $display("%0t: size expected %0d actual %0d", $time, want.out_size,
                         got.out_size);
                errors++;
            end
            if (got.hit !== want.hit) begin
                $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status,
                         got.status);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                errors++;
            end
            if (got.used_bytes !== want.used_bytes) begin
                $display("%0t: used bytes expected %0d actual %0d", $time,
                         want.used_bytes, got.used_bytes);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in         in_data;
    logic        out_valid;
    logic        out_ready;
    t_out        out_data;
    logic        cfg_we;
    logic        cfg_idx;
    logic [FILL_W-1:0] cfg_data;

    log_scoreboard sb;
    int          cycles;
    int          sent;
    bit          calm;        // no random idling on either side
    bit          hold_off;    // receiver asked to stall for a long stretch
    int          idle_pct;
    bit [31:0]   recent_ids[$];

    fifo_erase_block_log_cache_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog on total run length
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("fifo_erase_block_log_cache_top test failed");
            $finish;
        end
    end

    // result side: sample at the rising edge, change ready at the falling edge
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    end

    always @(negedge clk) begin
        if (!rst_n || hold_off) out_ready <= 1'b0;
        else if (calm) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(99) >= idle_pct);
    end

    // long receiver stall counted here, so the block backs up onto its input
    initial begin
        hold_off = 1'b0;
        wait (sent >= 150);
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
    end

    // present one command beat and hold it until accepted
    task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] id,
                            input logic [19:0] size);
        t_in c;
        c.command = cmd;
        c.item_id = id;
        c.item_size = size;
        while (!calm && $urandom_range(99) < idle_pct) @(negedge clk);
        in_valid <= 1'b1;
        in_data <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_command(c);
        sent++;
        @(negedge clk);
        in_valid <= 1'b0;
        if (recent_ids.size() > 40) void'(recent_ids.pop_front());
        recent_ids = {recent_ids, id};
        // valid goes low between beats
        @(negedge clk);
    endtask

    // wait until every expected beat is in, then let the block settle
    task automatic drain();
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (NUM_SLOTS + 100) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [FILL_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BLOCK_CAP) sb.cap_main = value;
        else sb.cap_last = value;
        @(negedge clk);
    endtask

    // mostly well-formed traffic: reuse recent ids so updates, lookups and
    // duplicates actually land on live objects
    task automatic random_phase(input int count, input int max_size);
        logic [1:0]  cmd;
        logic [31:0] id;
        logic [19:0] size;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 45) cmd = CMD_INSERT;
            else if (pick < 70) cmd = CMD_UPDATE;
            else if (pick < 95) cmd = CMD_LOOKUP;
            else cmd = 2'd3;
            if (recent_ids.size() > 0 && $urandom_range(99) < 50)
                id = recent_ids[$urandom_range(recent_ids.size() - 1)];
            else
                id = $urandom;
            if ($urandom_range(99) < 5) size = 20'($urandom);
            else size = 20'($urandom_range(max_size));
            send_cmd(cmd, id, size);
        end
    endtask

    initial begin
        sb = new();
        cycles = 0;
        sent = 0;
        calm = 1'b0;
        idle_pct = 38;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_BLOCK_CAP;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // small blocks so advances and flushes happen often
        write_reg(CFG_BLOCK_CAP, 24'd1000);
        write_reg(CFG_LAST_CAP, 24'd600);

        // directed: extremes, every command, the special cases
        send_cmd(CMD_LOOKUP, 32'h0, 20'd0);                 // miss on empty log
        send_cmd(CMD_INSERT, 32'h0, 20'd0);                 // zero size takes a slot
        send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 20'd999);       // nearly fills the open block
        send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 20'd5);         // duplicate
        send_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 20'hFFFFF);     // hit
        send_cmd(CMD_INSERT, 32'h1234_5678, 20'hFFFFF);     // oversize
        send_cmd(CMD_UPDATE, 32'hFFFF_FFFF, 20'hFFFFF);     // oversize update keeps copy
        send_cmd(CMD_UPDATE, 32'hFFFF_FFFF, 20'd400);       // update in place
        send_cmd(CMD_UPDATE, 32'hAAAA_5555, 20'd300);       // update of absent id
        send_cmd(2'd3, 32'hAAAA_5555, 20'h55555);           // unused command
        send_cmd(CMD_LOOKUP, 32'h5555_AAAA, 20'hAAAAA);
        for (int i = 0; i < 12; i++)                         // fill slots, zero sizes
            send_cmd(CMD_INSERT, 32'h100 + i, 20'd0);
        drain();

        // capacity changed while in use, then the extremes
        write_reg(CFG_BLOCK_CAP, 24'd1);
        write_reg(CFG_LAST_CAP, 24'hFFFFFF);
        random_phase(30, 2);
        drain();
        write_reg(CFG_BLOCK_CAP, 24'd3000);
        write_reg(CFG_LAST_CAP, 24'd1);
        random_phase(60, 700);
        drain();

        // pressure phase with long ready stretch
        write_reg(CFG_BLOCK_CAP, 24'd2000);
        write_reg(CFG_LAST_CAP, 24'd1500);
        calm = 1'b1;
        random_phase(60, 500);
        calm = 1'b0;
        random_phase(60, 900);
        drain();
        write_reg(CFG_BLOCK_CAP, 24'hFFFFFF);
        write_reg(CFG_LAST_CAP, 24'hFFFFFF);
        random_phase(50, 20'hFFFFF);
        drain();

        $display("sent %0d commands, checked %0d result beats including %0d evictions",
                 sent, sb.beats, sb.evictions);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("fifo_erase_block_log_cache_top test passed");
        else
            $display("fifo_erase_block_log_cache_top test failed");
        $finish;
    end
endmodule

`default_nettype wire
